### src/ita_pkg.sv
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types, codes and constant tables of the IoU track association block.
// ----------------------------------------------------------------------------
package ita_pkg;

    localparam int BOX_W   = 12;
    localparam int SCORE_W = 16;
    localparam int ID_W    = 16;
    localparam int KEEP_W  = 6;
    localparam int DECAY_W = 17;

    // Operation codes of an input item.
    localparam logic OP_DET = 1'b0;
    localparam logic OP_EOF = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_DET    = 2'd0;
    localparam logic [1:0] KIND_GHOST  = 2'd1;
    localparam logic [1:0] KIND_MARKER = 2'd2;

    localparam logic [KEEP_W-1:0] KEEP_RESET  = 6'd5;
    localparam logic [ID_W-1:0]   FRAME_RESET = 16'd1;

    typedef struct packed {
        logic               opcode;
        logic [BOX_W-1:0]   box_x;
        logic [BOX_W-1:0]   box_y;
        logic [BOX_W-1:0]   box_w;
        logic [BOX_W-1:0]   box_h;
        logic [SCORE_W-1:0] det_score;
    } req_t;

    typedef struct packed {
        logic [ID_W-1:0]    track_id;
        logic [BOX_W-1:0]   out_x;
        logic [BOX_W-1:0]   out_y;
        logic [BOX_W-1:0]   out_w;
        logic [BOX_W-1:0]   out_h;
        logic [SCORE_W-1:0] out_score;
        logic [1:0]         kind;
        logic               last;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DET_RD,
        ST_DET_GEOM,
        ST_DET_MUL,
        ST_DET_UNI,
        ST_DET_XMUL,
        ST_DET_CMP,
        ST_DET_WRITE,
        ST_FRM_RD,
        ST_FRM_AGE,
        ST_FRM_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic rd;
        logic geom;
        logic mul;
        logic uni;
        logic xmul;
        logic cmp;
        logic idx_inc;
        logic det_write;
        logic frm_age;
        logic frm_done;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_valid;
        logic ghost_cand;
        logic idx_last;
        logic xdone;
    } status_t;

    // Decay factors 0.7^age in Q1.16, one entry per age up to the keep-alive limit.
    typedef logic [(1 << KEEP_W)-1:0][DECAY_W-1:0] decay_lut_t;

    function automatic decay_lut_t build_decay_lut();
        decay_lut_t  lut;
        logic [63:0] p;
        lut    = '0;
        lut[0] = 17'd65536;
        p      = 64'h1_0000_0000;
        for (int a = 1; a < (1 << KEEP_W); a++)
        begin
            p      = (p * 64'd7 + 64'd5) / 64'd10;
            lut[a] = DECAY_W'((p + 64'd32768) >> 16);
        end
        return lut;
    endfunction

    localparam decay_lut_t DECAY_LUT = build_decay_lut();

endpackage

### src/ita_ram.sv
// ----------------------------------------------------------------------------
// ita_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ita_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/ita_ctrl.sv
// ----------------------------------------------------------------------------
// ita_ctrl
// Controller: sequences the slot scan for detections and end-of-frame items.
// ----------------------------------------------------------------------------
module ita_ctrl
    import ita_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    opcode,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = (opcode == OP_EOF) ? ST_FRM_RD : ST_DET_RD;
                end
            end
            ST_DET_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_DET_GEOM;
            end
            ST_DET_GEOM:
            begin
                cmd.geom = 1'b1;
                if (status.slot_valid)
                begin
                    state_next = ST_DET_MUL;
                end
                else if (status.idx_last)
                begin
                    state_next = ST_DET_WRITE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_DET_RD;
                end
            end
            ST_DET_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DET_UNI;
            end
            ST_DET_UNI:
            begin
                cmd.uni    = 1'b1;
                state_next = ST_DET_XMUL;
            end
            ST_DET_XMUL:
            begin
                cmd.xmul = 1'b1;
                if (status.xdone)
                begin
                    state_next = ST_DET_CMP;
                end
            end
            ST_DET_CMP:
            begin
                cmd.cmp = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_DET_WRITE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_DET_RD;
                end
            end
            ST_DET_WRITE:
            begin
                cmd.det_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_FRM_RD:
            begin
                if (status.ghost_cand)
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_FRM_AGE;
                end
                else if (status.idx_last)
                begin
                    state_next = ST_FRM_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_FRM_AGE:
            begin
                cmd.frm_age = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_FRM_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_FRM_RD;
                end
            end
            ST_FRM_DONE:
            begin
                cmd.frm_done = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### src/ita_dp.sv
// ----------------------------------------------------------------------------
// ita_dp
// Datapath: slot memory, IoU arithmetic, best-match tracking, ghost decay and
// the result register.
// ----------------------------------------------------------------------------
module ita_dp
    import ita_pkg::*;
#(
    parameter int TRACK_SLOTS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  req_t              item,
    input  logic              cfg_we,
    input  logic [KEEP_W-1:0] cfg_data,
    input  cmd_t              cmd,
    output status_t           status,
    output logic              result_valid,
    output res_t              result
);

    localparam int C      = BOX_W;
    localparam int IW     = $clog2(TRACK_SLOTS);
    localparam int SW     = C + 1;
    localparam int UW     = 2 * C + 1;
    localparam int HW     = (UW + 1) / 2;
    localparam int PW     = 2 * HW;
    localparam int ACCW   = 4 * HW;
    localparam int TW     = UW + 4;
    localparam int EW     = 4 * C + 48;
    localparam int SC_LSB = 4 * C;
    localparam int LF_LSB = 4 * C + 16;
    localparam int ID_LSB = 4 * C + 32;

    // Configuration and frame bookkeeping.
    logic [KEEP_W-1:0]      keep_reg;
    logic [ID_W-1:0]        frame_reg;
    logic [ID_W-1:0]        next_id_reg;
    logic [TRACK_SLOTS-1:0] valid_reg;
    logic [TRACK_SLOTS-1:0] valid_next;
    logic [TRACK_SLOTS-1:0] matched_reg;
    logic [TRACK_SLOTS-1:0] matched_next;
    logic [IW-1:0]          idx_reg;

    // Latched detection.
    logic [C-1:0]       ax_reg;
    logic [C-1:0]       ay_reg;
    logic [C-1:0]       aw_reg;
    logic [C-1:0]       ah_reg;
    logic [SCORE_W-1:0] ascore_reg;
    logic [2*C-1:0]     area_a_reg;

    // Per-slot IoU pipeline.
    logic [ID_W-1:0] cur_id_reg;
    logic [C-1:0]    iw_reg;
    logic [C-1:0]    ih_reg;
    logic [C-1:0]    bw_reg;
    logic [C-1:0]    bh_reg;
    logic [2*C-1:0]  inter_reg;
    logic [2*C-1:0]  area_b_reg;
    logic [UW-1:0]   inter_c_reg;
    logic [UW-1:0]   uni_c_reg;
    logic [1:0]      xstep_reg;
    logic [ACCW-1:0] lhs_reg;
    logic [ACCW-1:0] rhs_reg;

    // Best match and new-slot candidates.
    logic            found_reg;
    logic [IW-1:0]   best_slot_reg;
    logic [ID_W-1:0] best_id_reg;
    logic [UW-1:0]   best_inter_reg;
    logic [UW-1:0]   best_uni_reg;
    logic            hit_found_reg;
    logic [IW-1:0]   hit_slot_reg;
    logic            free_found_reg;
    logic [IW-1:0]   free_slot_reg;
    logic [IW-1:0]   old_slot_reg;
    logic [ID_W-1:0] old_age_reg;

    // Result register.
    logic result_valid_reg;
    logic result_valid_next;
    res_t result_reg;
    res_t result_next;

    // Slot memory.
    logic [EW-1:0] ram_rdata;
    logic [EW-1:0] ram_wdata;
    logic [IW-1:0] wslot;

    logic [C-1:0]       rd_x;
    logic [C-1:0]       rd_y;
    logic [C-1:0]       rd_w;
    logic [C-1:0]       rd_h;
    logic [SCORE_W-1:0] rd_score;
    logic [ID_W-1:0]    rd_last;
    logic [ID_W-1:0]    rd_id;

    logic [SW-1:0]   a_xend;
    logic [SW-1:0]   a_yend;
    logic [SW-1:0]   b_xend;
    logic [SW-1:0]   b_yend;
    logic [C-1:0]    x1;
    logic [C-1:0]    y1;
    logic [SW-1:0]   x2;
    logic [SW-1:0]   y2;
    logic [C-1:0]    iw;
    logic [C-1:0]    ih;
    logic [ID_W-1:0] age;

    logic [HW-1:0]   la;
    logic [HW-1:0]   lb;
    logic [HW-1:0]   ra;
    logic [HW-1:0]   rb;
    logic [PW-1:0]   lp;
    logic [PW-1:0]   rp;
    logic [ACCW-1:0] lsh;
    logic [ACCW-1:0] rsh;

    logic            better;
    logic [TW-1:0]   ten_inter;
    logic [TW-1:0]   three_uni;
    logic            is_match;
    logic [ID_W-1:0] wid;

    logic                     eligible;
    logic [2*SCORE_W:0]       gprod;
    logic [SCORE_W-1:0]       gscore;

    assign rd_x     = ram_rdata[C-1:0];
    assign rd_y     = ram_rdata[2*C-1:C];
    assign rd_w     = ram_rdata[3*C-1:2*C];
    assign rd_h     = ram_rdata[4*C-1:3*C];
    assign rd_score = ram_rdata[SC_LSB +: SCORE_W];
    assign rd_last  = ram_rdata[LF_LSB +: ID_W];
    assign rd_id    = ram_rdata[ID_LSB +: ID_W];

    // Intersection extents of the detection and the slot just read.
    always_comb
    begin
        a_xend = SW'(ax_reg) + SW'(aw_reg);
        a_yend = SW'(ay_reg) + SW'(ah_reg);
        b_xend = SW'(rd_x) + SW'(rd_w);
        b_yend = SW'(rd_y) + SW'(rd_h);
        x1     = (ax_reg > rd_x) ? ax_reg : rd_x;
        y1     = (ay_reg > rd_y) ? ay_reg : rd_y;
        x2     = (a_xend < b_xend) ? a_xend : b_xend;
        y2     = (a_yend < b_yend) ? a_yend : b_yend;
        iw     = (x2 > SW'(x1)) ? C'(x2 - SW'(x1)) : '0;
        ih     = (y2 > SW'(y1)) ? C'(y2 - SW'(y1)) : '0;
        age    = frame_reg - rd_last;
    end

    // One partial product of each cross-multiplication per step.
    always_comb
    begin
        la  = xstep_reg[1] ? HW'(inter_c_reg >> HW) : inter_c_reg[HW-1:0];
        lb  = xstep_reg[0] ? HW'(best_uni_reg >> HW) : best_uni_reg[HW-1:0];
        ra  = xstep_reg[1] ? HW'(best_inter_reg >> HW) : best_inter_reg[HW-1:0];
        rb  = xstep_reg[0] ? HW'(uni_c_reg >> HW) : uni_c_reg[HW-1:0];
        lp  = PW'(la) * PW'(lb);
        rp  = PW'(ra) * PW'(rb);
        case (xstep_reg)
            2'd0:
            begin
                lsh = ACCW'(lp);
                rsh = ACCW'(rp);
            end
            2'd1, 2'd2:
            begin
                lsh = ACCW'(lp) << HW;
                rsh = ACCW'(rp) << HW;
            end
            default:
            begin
                lsh = ACCW'(lp) << (2 * HW);
                rsh = ACCW'(rp) << (2 * HW);
            end
        endcase
    end

    // Best-match test and the threshold IoU > 3/10 as 10*inter > 3*union.
    always_comb
    begin
        better = (inter_c_reg != '0) &&
                 (!found_reg || (lhs_reg > rhs_reg) ||
                  ((lhs_reg == rhs_reg) && (cur_id_reg < best_id_reg)));
        ten_inter = TW'({best_inter_reg, 3'b000}) + TW'({best_inter_reg, 1'b0});
        three_uni = TW'({best_uni_reg, 1'b0}) + TW'(best_uni_reg);
        is_match  = found_reg && (ten_inter > three_uni);
        if (is_match)
        begin
            wslot = best_slot_reg;
        end
        else if (hit_found_reg)
        begin
            wslot = hit_slot_reg;
        end
        else if (free_found_reg)
        begin
            wslot = free_slot_reg;
        end
        else
        begin
            wslot = old_slot_reg;
        end
        wid       = is_match ? best_id_reg : next_id_reg;
        ram_wdata = {wid, frame_reg, ascore_reg, ah_reg, aw_reg, ay_reg, ax_reg};
    end

    // Ghost eligibility and decayed score.
    always_comb
    begin
        eligible = (age <= ID_W'(keep_reg));
        gprod    = (2*SCORE_W+1)'(rd_score) * (2*SCORE_W+1)'(DECAY_LUT[age[KEEP_W-1:0]]);
        gscore   = SCORE_W'((gprod + (2*SCORE_W+1)'(32768)) >> 16);
    end

    // Valid and matched bits.
    always_comb
    begin
        valid_next   = valid_reg;
        matched_next = matched_reg;
        if (cmd.det_write)
        begin
            valid_next[wslot]   = 1'b1;
            matched_next[wslot] = 1'b1;
        end
        if (cmd.frm_done)
        begin
            matched_next = '0;
        end
    end

    // Next result.
    always_comb
    begin
        result_valid_next = 1'b0;
        result_next       = result_reg;
        if (cmd.det_write)
        begin
            result_valid_next     = 1'b1;
            result_next.track_id  = wid;
            result_next.out_x     = BOX_W'(ax_reg);
            result_next.out_y     = BOX_W'(ay_reg);
            result_next.out_w     = BOX_W'(aw_reg);
            result_next.out_h     = BOX_W'(ah_reg);
            result_next.out_score = ascore_reg;
            result_next.kind      = KIND_DET;
            result_next.last      = 1'b1;
        end
        else if (cmd.frm_age)
        begin
            result_valid_next     = eligible;
            result_next.track_id  = rd_id;
            result_next.out_x     = BOX_W'(rd_x);
            result_next.out_y     = BOX_W'(rd_y);
            result_next.out_w     = BOX_W'(rd_w);
            result_next.out_h     = BOX_W'(rd_h);
            result_next.out_score = gscore;
            result_next.kind      = KIND_GHOST;
            result_next.last      = 1'b0;
        end
        else if (cmd.frm_done)
        begin
            result_valid_next = 1'b1;
            result_next       = '0;
            result_next.kind  = KIND_MARKER;
            result_next.last  = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg         <= KEEP_RESET;
            frame_reg        <= FRAME_RESET;
            next_id_reg      <= '0;
            valid_reg        <= '0;
            matched_reg      <= '0;
            idx_reg          <= '0;
            xstep_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg        <= valid_next;
            matched_reg      <= matched_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                keep_reg <= cfg_data;
            end
            if (cmd.frm_done)
            begin
                frame_reg <= frame_reg + 1'b1;
            end
            if (cmd.det_write && !is_match)
            begin
                next_id_reg <= next_id_reg + 1'b1;
            end
            if (cmd.accept)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.uni)
            begin
                xstep_reg <= '0;
            end
            else if (cmd.xmul)
            begin
                xstep_reg <= xstep_reg + 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        if (cmd.accept)
        begin
            ax_reg         <= C'(item.box_x);
            ay_reg         <= C'(item.box_y);
            aw_reg         <= C'(item.box_w);
            ah_reg         <= C'(item.box_h);
            ascore_reg     <= item.det_score;
            area_a_reg     <= (2*C)'(C'(item.box_w)) * (2*C)'(C'(item.box_h));
            found_reg      <= 1'b0;
            best_inter_reg <= '0;
            best_uni_reg   <= UW'(1);
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        if (cmd.geom)
        begin
            cur_id_reg <= rd_id;
            iw_reg     <= iw;
            ih_reg     <= ih;
            bw_reg     <= rd_w;
            bh_reg     <= rd_h;
            if (!hit_found_reg && valid_reg[idx_reg] && (rd_id == next_id_reg))
            begin
                hit_found_reg <= 1'b1;
                hit_slot_reg  <= idx_reg;
            end
            if (!free_found_reg && !valid_reg[idx_reg])
            begin
                free_found_reg <= 1'b1;
                free_slot_reg  <= idx_reg;
            end
            if ((idx_reg == '0) || (age > old_age_reg))
            begin
                old_age_reg  <= age;
                old_slot_reg <= idx_reg;
            end
        end
        if (cmd.mul)
        begin
            inter_reg  <= (2*C)'(iw_reg) * (2*C)'(ih_reg);
            area_b_reg <= (2*C)'(bw_reg) * (2*C)'(bh_reg);
        end
        if (cmd.uni)
        begin
            inter_c_reg <= UW'(inter_reg);
            uni_c_reg   <= UW'(area_a_reg) + UW'(area_b_reg) - UW'(inter_reg);
            lhs_reg     <= '0;
            rhs_reg     <= '0;
        end
        if (cmd.xmul)
        begin
            lhs_reg <= lhs_reg + lsh;
            rhs_reg <= rhs_reg + rsh;
        end
        if (cmd.cmp && better)
        begin
            found_reg      <= 1'b1;
            best_slot_reg  <= idx_reg;
            best_id_reg    <= cur_id_reg;
            best_inter_reg <= inter_c_reg;
            best_uni_reg   <= uni_c_reg;
        end
    end

    ita_ram #(
        .WIDTH (EW),
        .DEPTH (TRACK_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (cmd.det_write),
        .waddr (wslot),
        .wdata (ram_wdata),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // Status to the controller.
    always_comb
    begin
        status.slot_valid = valid_reg[idx_reg];
        status.ghost_cand = valid_reg[idx_reg] && !matched_reg[idx_reg];
        status.idx_last   = (idx_reg == IW'(TRACK_SLOTS - 1));
        status.xdone      = (xstep_reg == 2'd3);
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### src/iou_track_association.sv
// ----------------------------------------------------------------------------
// iou_track_association
// Greedy IoU track association: matches detections to stored tracks, emits
// decayed ghost tracks and a marker at the end of each frame.
// ----------------------------------------------------------------------------
//  Channel | Ports                          | Transaction
//  --------+--------------------------------+------------------------------
//  item    | start, busy, item              | start high while busy low
//  config  | cfg_valid, cfg_ready, cfg_data | cfg_valid and cfg_ready high
//  result  | result_valid, result           | one-cycle strobe, no stall
//
// A detection scans every slot before its result: each occupied slot costs a
// memory read, the geometry, the area products, the union, four steps of the
// shared cross-multiplier and the compare; a free slot costs the read and the
// geometry. An end-of-frame item scans every slot and emits a decayed ghost for
// each unmatched track within keep-alive, then the marker.
// Reset clears the valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module iou_track_association
    import ita_pkg::*;
#(
    parameter int TRACK_SLOTS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  req_t              item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [KEEP_W-1:0] cfg_data,
    output logic              result_valid,
    output res_t              result
);

    cmd_t    cmd;
    status_t status;

    // Configuration is taken only while no transaction is in progress.
    assign cfg_ready = !busy;

    ita_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (item.opcode),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    ita_dp #(
        .TRACK_SLOTS (TRACK_SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

### src/ita_checker.sv
// ----------------------------------------------------------------------------
// ita_checker
// Port-level checks of the track association block, bound to the top level.
// ----------------------------------------------------------------------------
module ita_checker
    import ita_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic result_valid,
    input res_t result
);

    // An accepted item keeps the block busy in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
    else $error("block not busy after an accepted transaction");

    // Ghosts are never the final result of an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind == KIND_GHOST) |-> !result.last)
    else $error("ghost result marked last");

    // Detection echoes and frame markers close their item.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.kind != KIND_GHOST) |-> result.last)
    else $error("detection or marker result not marked last");

    // Ghosts only appear while the end-of-frame item is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> busy)
    else $error("non-final result while idle");

    // No result follows the final one in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |=> !result_valid)
    else $error("result directly after a final result");

endmodule

bind iou_track_association ita_checker u_ita_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the IoU track association block. A queue of
// detections, end-of-frame items and keep-alive writes drives the block
// through randomly gapped transactions. A behavioural track table predicts
// every result, and the monitor compares each one field by field.
// ----------------------------------------------------------------------------
module testbench;
    import ita_pkg::*;

    localparam int SLOTS = 32;

    typedef struct {
        logic              is_cfg;
        req_t              req;
        logic [KEEP_W-1:0] keep;
    } pend_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    req_t              item = '0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [KEEP_W-1:0] cfg_data = '0;
    logic              result_valid;
    res_t              result;

    pend_t pending[$];
    res_t  track_results[$];
    int    errors = 0;
    int    gap = 0;
    int    quiet = 0;
    bit    gaps_on = 1'b1;
    int    n_det = 0;
    int    n_ghost = 0;
    int    n_marker = 0;
    int    n_cfg = 0;

    // Behavioural copy of the track table.
    bit              trk_valid[SLOTS];
    bit              trk_matched[SLOTS];
    logic [15:0]     trk_id[SLOTS];
    logic [11:0]     trk_x[SLOTS], trk_y[SLOTS], trk_w[SLOTS], trk_h[SLOTS];
    logic [15:0]     trk_score[SLOTS];
    logic [15:0]     trk_seen[SLOTS];
    logic [15:0]     frame_no = FRAME_RESET;
    logic [15:0]     fresh_id = 16'd0;
    logic [KEEP_W-1:0] keep_alive = KEEP_RESET;

    iou_track_association u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always #2 clk = ~clk;

    // Decay factor 0.7^age in Q1.16, rounded from a Q32 running product.
    function automatic longint unsigned decay_factor(input int age);
        longint unsigned p;
        p = 64'h1_0000_0000;
        if (age == 0)
            return 65536;
        for (int i = 0; i < age; i++)
            p = (p * 7 + 5) / 10;
        return (p + 32768) >> 16;
    endfunction

    // Update the track table for one accepted transaction and queue its results.
    task automatic predict_tracks(input req_t r);
        longint unsigned ax, ay, aw, ah, bx, by, bw, bh;
        longint unsigned x1, y1, x2, y2, iw, ih, it, un, b_it, b_un, lhs, rhs;
        bit              found;
        int              b_slot, slot;
        logic [15:0]     id, age, best_age;
        res_t            res;
        found = 0;
        b_slot = 0;
        b_it = 0;
        b_un = 1;
        slot = -1;
        res = '0;
        if (r.opcode == OP_DET)
        begin
            ax = r.box_x; ay = r.box_y; aw = r.box_w; ah = r.box_h;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!trk_valid[i])
                    continue;
                bx = trk_x[i]; by = trk_y[i]; bw = trk_w[i]; bh = trk_h[i];
                x1 = ax > bx ? ax : bx;
                y1 = ay > by ? ay : by;
                x2 = (ax + aw) < (bx + bw) ? ax + aw : bx + bw;
                y2 = (ay + ah) < (by + bh) ? ay + ah : by + bh;
                iw = x2 > x1 ? x2 - x1 : 0;
                ih = y2 > y1 ? y2 - y1 : 0;
                it = iw * ih;
                un = aw * ah + bw * bh - it;
                if (un == 0 || it == 0)
                    continue;
                lhs = it * b_un;
                rhs = b_it * un;
                if (!found || lhs > rhs || (lhs == rhs && trk_id[i] < trk_id[b_slot]))
                begin
                    found = 1;
                    b_slot = i;
                    b_it = it;
                    b_un = un;
                end
            end
            if (found && b_it * 10 > b_un * 3)
            begin
                slot = b_slot;
                id = trk_id[slot];
            end
            else
            begin
                id = fresh_id;
                fresh_id = fresh_id + 16'd1;
                // Reuse a slot holding the same id, else a free one, else the oldest.
                for (int i = 0; i < SLOTS && slot < 0; i++)
                    if (trk_valid[i] && trk_id[i] == id)
                        slot = i;
                for (int i = 0; i < SLOTS && slot < 0; i++)
                    if (!trk_valid[i])
                        slot = i;
                if (slot < 0)
                begin
                    slot = 0;
                    best_age = frame_no - trk_seen[0];
                    for (int i = 1; i < SLOTS; i++)
                    begin
                        age = frame_no - trk_seen[i];
                        if (age > best_age)
                        begin
                            best_age = age;
                            slot = i;
                        end
                    end
                end
            end
            trk_valid[slot] = 1;
            trk_matched[slot] = 1;
            trk_id[slot] = id;
            trk_x[slot] = r.box_x; trk_y[slot] = r.box_y;
            trk_w[slot] = r.box_w; trk_h[slot] = r.box_h;
            trk_score[slot] = r.det_score;
            trk_seen[slot] = frame_no;
            res.track_id = id;
            res.out_x = r.box_x; res.out_y = r.box_y;
            res.out_w = r.box_w; res.out_h = r.box_h;
            res.out_score = r.det_score;
            res.kind = KIND_DET;
            res.last = 1'b1;
            track_results = {track_results, res};
        end
        else
        begin
            // Ghosts of unmatched tracks still within keep-alive, then the marker.
            for (int i = 0; i < SLOTS; i++)
            begin
                age = frame_no - trk_seen[i];
                if (!trk_valid[i] || trk_matched[i] || age > keep_alive)
                    continue;
                res = '0;
                res.track_id = trk_id[i];
                res.out_x = trk_x[i]; res.out_y = trk_y[i];
                res.out_w = trk_w[i]; res.out_h = trk_h[i];
                res.out_score = 16'((trk_score[i] * decay_factor(age) + 32768) >> 16);
                res.kind = KIND_GHOST;
                res.last = 1'b0;
                track_results = {track_results, res};
            end
            res = '0;
            res.kind = KIND_MARKER;
            res.last = 1'b1;
            track_results = {track_results, res};
            for (int i = 0; i < SLOTS; i++)
                trk_matched[i] = 0;
            frame_no = frame_no + 16'd1;
        end
    endtask

    // Driver: one transaction at a time from the pending queue.
    always @(posedge clk or negedge rst_n)
    begin
        logic  nxt_start;
        logic  nxt_cfg;
        pend_t p;
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_valid <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                predict_tracks(item);
            if (cfg_valid && cfg_ready)
            begin
                keep_alive = cfg_data;
                n_cfg++;
            end
            quiet = (track_results.size() == 0 && !result_valid && !busy) ? quiet + 1 : 0;
            nxt_start = start && busy;
            nxt_cfg = cfg_valid && !cfg_ready;
            if (!nxt_start && !nxt_cfg)
            begin
                if (gap > 0)
                    gap--;
                else if (pending.size() > 0)
                begin
                    if (!pending[0].is_cfg)
                    begin
                        p = pending.pop_front();
                        item <= p.req;
                        nxt_start = 1'b1;
                    end
                    else if (quiet >= 8 && !(start && !busy))
                    begin
                        p = pending.pop_front();
                        cfg_data <= p.keep;
                        nxt_cfg = 1'b1;
                    end
                    if (pending.size() < 30)
                        gaps_on = 0;
                    if (gaps_on && $urandom_range(0, 3) == 0)
                        gap = $urandom_range(1, 17);
                end
            end
            start <= nxt_start;
            cfg_valid <= nxt_cfg;
        end
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Monitor: every strobed result against the oldest expectation.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && result_valid)
        begin
            if (track_results.size() == 0)
            begin
                $error("unexpected result: track_id %0d kind %0d",
                       result.track_id, result.kind);
                errors++;
            end
            else
            begin
                want = track_results.pop_front();
                check_field("track_id", want.track_id, result.track_id);
                check_field("out_x", want.out_x, result.out_x);
                check_field("out_y", want.out_y, result.out_y);
                check_field("out_w", want.out_w, result.out_w);
                check_field("out_h", want.out_h, result.out_h);
                check_field("out_score", want.out_score, result.out_score);
                check_field("kind", want.kind, result.kind);
                check_field("last", want.last, result.last);
                case (want.kind)
                    KIND_DET:   n_det++;
                    KIND_GHOST: n_ghost++;
                    default:    n_marker++;
                endcase
            end
        end
    end

    task automatic add_det(input int x, input int y, input int w, input int h,
                           input int s);
        pend_t p;
        p.is_cfg = 0;
        p.keep = '0;
        p.req.opcode = OP_DET;
        p.req.box_x = 12'(x);
        p.req.box_y = 12'(y);
        p.req.box_w = 12'(w);
        p.req.box_h = 12'(h);
        p.req.det_score = 16'(s);
        pending = {pending, p};
    endtask

    task automatic add_eof();
        pend_t p;
        p.is_cfg = 0;
        p.keep = '0;
        p.req = req_t'({$urandom, $urandom});
        p.req.opcode = OP_EOF;
        pending = {pending, p};
    endtask

    task automatic add_keep(input int v);
        pend_t p;
        p.is_cfg = 1;
        p.req = '0;
        p.keep = KEEP_W'(v);
        pending = {pending, p};
    endtask

    // A scene of moving objects seen over several frames, plus stray boxes.
    task automatic add_frames(input int frames);
        int ox[8], oy[8], ow[8], oh[8];
        for (int k = 0; k < 8; k++)
        begin
            ox[k] = $urandom_range(0, 3800); oy[k] = $urandom_range(0, 3800);
            ow[k] = $urandom_range(8, 250);  oh[k] = $urandom_range(8, 250);
        end
        for (int f = 0; f < frames; f++)
        begin
            for (int k = 0; k < 8; k++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    ox[k] = $urandom_range(0, 3800);
                    oy[k] = $urandom_range(0, 3800);
                end
                if ($urandom_range(0, 3) != 0)
                    add_det(ox[k] + $urandom_range(0, 6), oy[k] + $urandom_range(0, 6),
                            ow[k] + $urandom_range(0, 4), oh[k] + $urandom_range(0, 4),
                            $urandom_range(0, 65535));
            end
            if ($urandom_range(0, 2) == 0)
                add_det($urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 65535));
            add_eof();
        end
    endtask

    // Stimulus and end of run.
    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            trk_valid[i] = 0; trk_matched[i] = 0; trk_id[i] = '0;
            trk_x[i] = '0; trk_y[i] = '0; trk_w[i] = '0; trk_h[i] = '0;
            trk_score[i] = '0; trk_seen[i] = '0;
        end

        // Directed: empty frame, extremes, exact and borderline matches, ties.
        add_eof();
        add_det(4095, 4095, 4095, 4095, 65535);
        add_det(0, 0, 0, 0, 0);
        add_det(0, 0, 4095, 4095, 12345);
        add_det(100, 100, 100, 100, 40000);
        add_det(100, 100, 100, 100, 40001);
        add_eof();
        add_det(130, 100, 100, 100, 1000);
        add_det(600, 600, 100, 100, 500);
        add_det(800, 600, 100, 100, 501);
        add_det(700, 600, 100, 100, 502);
        add_eof();
        add_eof();
        add_keep(0);
        add_eof();
        add_det(146, 100, 100, 100, 7);
        add_eof();
        add_keep(63);
        add_det(4000, 4000, 0, 95, 65535);
        add_eof();

        // Random scenes under several keep-alive settings.
        add_frames(6);
        add_keep(63);
        add_frames(5);
        add_keep(0);
        add_frames(4);
        add_keep($urandom_range(1, 62));
        add_frames(6);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending.size() == 0 && !start && !cfg_valid && track_results.size() == 0);
        repeat (400) @(posedge clk);
        if (track_results.size() != 0)
        begin
            $error("%0d expected results never arrived", track_results.size());
            errors++;
        end
        $display("Covered %0d detections, %0d ghosts, %0d frame markers, %0d keep-alive writes.",
                 n_det, n_ghost, n_marker, n_cfg);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5ms;
        $display("Run timed out.");
        $display("CHECK FAILED");
        $finish;
    end

endmodule

### filelist.f
src/ita_pkg.sv
src/ita_ram.sv
src/ita_ctrl.sv
src/ita_dp.sv
src/iou_track_association.sv
src/ita_checker.sv
tb/testbench.sv
